/* rtl/mfsk_tone_frame_decoder_top_macros.svh */
// assertion macros of the mfsk tone frame decoder checker
`ifndef MFSK_TONE_FRAME_DECODER_TOP_MACROS_SVH
`define MFSK_TONE_FRAME_DECODER_TOP_MACROS_SVH

// checked on every edge outside reset
`define MTFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// checked on every edge, reset included
`define MTFD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/mtfd_pkg.sv */
// shared constants and types of the mfsk tone frame decoder
`default_nettype none

package mtfd_pkg;

    // symbol geometry
    localparam int SYMBOL_BITS    = 2;
    localparam int SYMS_PER_BYTE  = 8 / SYMBOL_BITS;
    localparam int NUM_DATA_TONES = 1 << SYMBOL_BITS;

    // widths
    localparam int FREQ_W     = 20;
    localparam int TONE_W     = 22;
    localparam int WIN_W      = 16;
    localparam int CLASS_W    = 5;
    localparam int CNT_W      = 4;
    localparam int STATUS_W   = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 32;

    // m_tdata field positions
    localparam int DBYTE_LSB = STATUS_W;
    localparam int DIDX_LSB  = STATUS_W + 8;
    localparam int MLEN_LSB  = STATUS_W + 16;
    localparam int M_USED_W  = STATUS_W + 24;

    // tone classes
    localparam logic [CLASS_W-1:0] CLASS_NONE      = '0;
    localparam logic [CLASS_W-1:0] CLASS_GUARD_A   = CLASS_W'(NUM_DATA_TONES + 1);
    localparam logic [CLASS_W-1:0] CLASS_GUARD_B   = CLASS_W'(NUM_DATA_TONES + 2);
    localparam logic [CLASS_W-1:0] CLASS_SEPARATOR = CLASS_W'(NUM_DATA_TONES + 3);

    // status codes on the result beat
    localparam logic [STATUS_W-1:0] STATUS_WAIT    = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_GUARD_A = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_HEADER  = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_BODY    = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_DONE    = 3'd4;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_BASE_TONE      = 3'd0,
        REG_TONE_SPACING   = 3'd1,
        REG_GUARD_A_TONE   = 3'd2,
        REG_GUARD_B_TONE   = 3'd3,
        REG_SEPARATOR_TONE = 3'd4,
        REG_MATCH_WINDOW   = 3'd5
    } cfg_reg_t;

    // decoder phase, one-hot
    typedef enum logic [4:0] {
        PH_WAIT    = 5'b00001,
        PH_GUARD_A = 5'b00010,
        PH_HEADER  = 5'b00100,
        PH_BODY    = 5'b01000,
        PH_DONE    = 5'b10000
    } phase_t;

endpackage

`default_nettype wire

/* rtl/mfsk_tone_frame_decoder_top.sv */
// mfsk tone frame decoder: tone classifier, sync and byte assembly
`default_nettype none

// One input beat carries one measured peak frequency (sixteenth hertz units) or a
// restart request, and every input beat gives exactly one result beat. The block
// takes one beat per clock cycle when the result side keeps up. A beat taken into
// the input register passes into the result register as soon as that register is
// free to take it, and the single pass of tone compares and state update sits
// between those two registers; a stalled result register holds its beat. The
// frequency is classified against the data tones base_tone +
// i * tone_spacing (lowest i first), then guard A, guard B and the separator; a
// match needs an absolute difference strictly below match_window. A tone equal to
// the previous accepted tone is ignored, guard A excepted. Guard A directly
// followed by guard B syncs the decoder; the next 8/SYMBOL_BITS data symbols, MSB
// first, give the length byte, and every further group of symbols gives one body
// byte, flagged on m_tuser. A zero length completes at once; once complete,
// frequency beats are ignored until a restart beat (s_tuser high) clears the
// decoder. Configuration writes (index 0 base_tone, 1 tone_spacing, 2 guard_a_tone,
// 3 guard_b_tone, 4 separator_tone, 5 match_window) take effect after the write;
// the user makes them only while the block is idle, the block does not enforce it.
module mfsk_tone_frame_decoder_top
    import mtfd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // frequency[19:0], zero pad
    input  wire logic                  s_tuser,   // req_type (1 restart)
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // status[2:0], data_byte[10:3],
                                                  // byte_index[18:11],
                                                  // message_length[26:19], zero pad
    output logic                       m_tuser,   // byte_valid
    // configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_wr_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data
);

    // configuration registers
    logic [FREQ_W-1:0] base_tone_reg, tone_spacing_reg;
    logic [FREQ_W-1:0] guard_a_tone_reg, guard_b_tone_reg, separator_tone_reg;
    logic [WIN_W-1:0]  match_window_reg;

    // data tone centres, worked out from the config registers and registered
    logic [TONE_W-1:0] data_tone_reg [NUM_DATA_TONES];

    // input stage
    logic              in_valid_reg;
    logic              req_reg;
    logic [FREQ_W-1:0] freq_reg;

    // decoder state
    phase_t              phase_reg, phase_next;
    logic [CLASS_W-1:0]  last_class_reg, last_class_next;
    logic [CNT_W-1:0]    sym_cnt_reg, sym_cnt_next;
    logic [7:0]          shift_reg, shift_next;
    logic [7:0]          length_reg, length_next;
    logic [7:0]          recv_reg, recv_next;

    // result stage
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                byte_valid_reg, byte_valid_next;
    logic [7:0]          data_byte_reg, data_byte_next;
    logic [7:0]          byte_index_reg, byte_index_next;

    logic advance;   // result register free to take the input stage
    logic fire;      // input stage moves into the result register this cycle

    logic [NUM_DATA_TONES-1:0] data_hit;
    logic                      guard_a_hit, guard_b_hit, sep_hit;
    logic [CLASS_W-1:0]        cls;
    logic [TONE_W-1:0]         freq_ext;

    logic [SYMBOL_BITS-1:0]    sym;
    logic [CNT_W-1:0]          sym_shift;
    logic [7:0]                shift_merged;
    logic [7:0]                recv_inc;

    function automatic logic near_tone(input logic [TONE_W-1:0] f,
                                       input logic [TONE_W-1:0] t,
                                       input logic [WIN_W-1:0]  w);
        logic [TONE_W-1:0] d;
        d = (f >= t) ? (f - t) : (t - f);
        return d < TONE_W'(w);
    endfunction

    // handshake: the input register refills whenever it moves on
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = aresetn && (!in_valid_reg || advance);

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = byte_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - M_USED_W){1'b0}}, length_reg, byte_index_reg,
                       data_byte_reg, status_reg};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_tone_reg      <= FREQ_W'(16000);
            tone_spacing_reg   <= FREQ_W'(3200);
            guard_a_tone_reg   <= FREQ_W'(48000);
            guard_b_tone_reg   <= FREQ_W'(51200);
            separator_tone_reg <= FREQ_W'(41600);
            match_window_reg   <= WIN_W'(800);
        end else if (cfg_wr_en) begin
            case (cfg_wr_addr)
                REG_BASE_TONE:      base_tone_reg      <= cfg_wr_data;
                REG_TONE_SPACING:   tone_spacing_reg   <= cfg_wr_data;
                REG_GUARD_A_TONE:   guard_a_tone_reg   <= cfg_wr_data;
                REG_GUARD_B_TONE:   guard_b_tone_reg   <= cfg_wr_data;
                REG_SEPARATOR_TONE: separator_tone_reg <= cfg_wr_data;
                REG_MATCH_WINDOW:   match_window_reg   <= cfg_wr_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // tone table: small constant multiples, so a few adders each
    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_DATA_TONES; i++) begin
            data_tone_reg[i] <= TONE_W'(base_tone_reg)
                              + TONE_W'(i) * TONE_W'(tone_spacing_reg);
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg  <= s_tuser;
            freq_reg <= s_tdata[FREQ_W-1:0];
        end
    end

    // tone classification, all compares in parallel
    assign freq_ext = TONE_W'(freq_reg);

    always_comb begin
        for (int i = 0; i < NUM_DATA_TONES; i++) begin
            data_hit[i] = near_tone(freq_ext, data_tone_reg[i], match_window_reg);
        end
        guard_a_hit = near_tone(freq_ext, TONE_W'(guard_a_tone_reg), match_window_reg);
        guard_b_hit = near_tone(freq_ext, TONE_W'(guard_b_tone_reg), match_window_reg);
        sep_hit     = near_tone(freq_ext, TONE_W'(separator_tone_reg), match_window_reg);
    end

    // priority: lowest data tone first, then guard a, guard b, separator
    always_comb begin
        cls = CLASS_NONE;
        if (sep_hit) begin
            cls = CLASS_SEPARATOR;
        end
        if (guard_b_hit) begin
            cls = CLASS_GUARD_B;
        end
        if (guard_a_hit) begin
            cls = CLASS_GUARD_A;
        end
        for (int i = NUM_DATA_TONES - 1; i >= 0; i--) begin
            if (data_hit[i]) begin
                cls = CLASS_W'(i + 1);
            end
        end
    end

    // symbol placement, MSB first
    assign sym          = SYMBOL_BITS'(cls - CLASS_W'(1));
    assign sym_shift    = CNT_W'(8 - SYMBOL_BITS) - CNT_W'(SYMBOL_BITS) * sym_cnt_reg;
    assign shift_merged = shift_reg | 8'(16'(sym) << sym_shift);
    assign recv_inc     = recv_reg + 8'd1;

    // decoder state update
    always_comb begin
        phase_next      = phase_reg;
        last_class_next = last_class_reg;
        sym_cnt_next    = sym_cnt_reg;
        shift_next      = shift_reg;
        length_next     = length_reg;
        recv_next       = recv_reg;
        byte_valid_next = 1'b0;
        data_byte_next  = 8'd0;
        byte_index_next = 8'd0;

        if (req_reg) begin
            // restart: decoder state back to its reset values
            phase_next      = PH_WAIT;
            last_class_next = CLASS_NONE;
            sym_cnt_next    = '0;
            shift_next      = 8'd0;
            length_next     = 8'd0;
            recv_next       = 8'd0;
        end else if (phase_reg != PH_DONE && cls != CLASS_NONE
                     && (cls != last_class_reg || cls == CLASS_GUARD_A)) begin
            last_class_next = cls;
            case (phase_reg)
                PH_WAIT: begin
                    if (cls == CLASS_GUARD_A) begin
                        phase_next = PH_GUARD_A;
                    end
                end
                PH_GUARD_A: begin
                    if (cls == CLASS_GUARD_A) begin
                        phase_next = PH_GUARD_A;
                    end else if (cls == CLASS_GUARD_B) begin
                        phase_next = PH_HEADER;
                    end else begin
                        phase_next = PH_WAIT;
                    end
                end
                PH_HEADER, PH_BODY: begin
                    // guards and separator only update the last tone here
                    if (cls <= CLASS_W'(NUM_DATA_TONES)) begin
                        if (sym_cnt_reg == CNT_W'(SYMS_PER_BYTE - 1)) begin
                            sym_cnt_next = '0;
                            shift_next   = 8'd0;
                            if (phase_reg == PH_HEADER) begin
                                length_next = shift_merged;
                                phase_next  = (shift_merged == 8'd0) ? PH_DONE : PH_BODY;
                            end else begin
                                byte_valid_next = 1'b1;
                                data_byte_next  = shift_merged;
                                byte_index_next = recv_reg;
                                recv_next       = recv_inc;
                                if (recv_inc == length_reg) begin
                                    phase_next = PH_DONE;
                                end
                            end
                        end else begin
                            sym_cnt_next = sym_cnt_reg + CNT_W'(1);
                            shift_next   = shift_merged;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        case (phase_next)
            PH_WAIT:    status_next = STATUS_WAIT;
            PH_GUARD_A: status_next = STATUS_GUARD_A;
            PH_HEADER:  status_next = STATUS_HEADER;
            PH_BODY:    status_next = STATUS_BODY;
            PH_DONE:    status_next = STATUS_DONE;
            default:    status_next = STATUS_WAIT;
        endcase
    end

    // state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_WAIT;
            last_class_reg <= CLASS_NONE;
            sym_cnt_reg    <= '0;
            shift_reg      <= 8'd0;
            length_reg     <= 8'd0;
            recv_reg       <= 8'd0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                phase_reg      <= phase_next;
                last_class_reg <= last_class_next;
                sym_cnt_reg    <= sym_cnt_next;
                shift_reg      <= shift_next;
                length_reg     <= length_next;
                recv_reg       <= recv_next;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (fire) begin
            status_reg     <= status_next;
            byte_valid_reg <= byte_valid_next;
            data_byte_reg  <= data_byte_next;
            byte_index_reg <= byte_index_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/mtfd_checker.sv */
// port-level checker for the mfsk tone frame decoder, with its bind
`default_nettype none
`include "mfsk_tone_frame_decoder_top_macros.svh"

module mtfd_checker
    import mtfd_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 m_tuser
);

    // a stalled result beat keeps its contents
    `MTFD_ASSERT(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

    // no result beat straight after reset
    `MTFD_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result valid after reset")

    // a body byte only leaves in body or complete status
    `MTFD_ASSERT(a_byte_status, m_tvalid && m_tuser |-> m_tdata[STATUS_W-1:0] == STATUS_BODY || m_tdata[STATUS_W-1:0] == STATUS_DONE, "body byte outside body phase")

    // a body byte implies a non-zero header length
    `MTFD_ASSERT(a_byte_length, m_tvalid && m_tuser |-> m_tdata[MLEN_LSB+7:MLEN_LSB] != 8'd0, "body byte with zero length")

    // without a byte, data and index read zero
    `MTFD_ASSERT(a_idle_zero, m_tvalid && !m_tuser |-> m_tdata[DIDX_LSB+7:DBYTE_LSB] == 16'd0, "byte fields set without byte valid")

endmodule

bind mfsk_tone_frame_decoder_top mtfd_checker u_mtfd_checker (.*);

`default_nettype wire

/* tb/mfsk_tone_frame_decoder_top_test.sv */
// self-checking testbench of the mfsk tone frame decoder: directed frames, random traffic
module mfsk_tone_frame_decoder_top_test;
    import mtfd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FREQ_MAX    = (1 << FREQ_W) - 1;
    localparam int STALL_LIMIT = 2000;   // cycles without any beat before giving up
    localparam int PRINT_LIMIT = 40;     // mismatch lines printed, the rest only counted

    // one result beat as the decoder should deliver it
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                byte_valid;
        logic [7:0]          data_byte;
        logic [7:0]          byte_index;
        logic [7:0]          msg_length;
    } decoded_beat_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;
    logic                  s_tuser     = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_wr_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    mfsk_tone_frame_decoder_top uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_addr (cfg_wr_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // shadow copy of the register file
    logic [FREQ_W-1:0] reg_base, reg_spacing, reg_guard_a, reg_guard_b, reg_separator;
    logic [WIN_W-1:0]  reg_window;

    // decoder state as the testbench sees it
    logic [STATUS_W-1:0] dec_phase;
    logic [CLASS_W-1:0]  dec_last_class;
    logic [CNT_W-1:0]    dec_sym_count;
    logic [7:0]          dec_shift;
    logic [7:0]          dec_length;
    logic [7:0]          dec_received;

    decoded_beat_t pending_beats[$];   // results still owed by the decoder, oldest first
    int  error_count  = 0;
    int  beats_sent   = 0;
    int  quiet_cycles = 0;
    int  sink_hold    = 0;
    bit  src_idle     = 1'b0;          // random gaps between input beats
    bit  sink_idle    = 1'b0;          // random back-pressure on the result side
    bit  disturb      = 1'b1;          // odd stray beats inside bytes

    // ------------------------------------------------------------------
    // decoder prediction
    // ------------------------------------------------------------------

    function automatic bit tone_hit(longint unsigned f, longint unsigned centre);
        longint unsigned diff;
        diff = (f >= centre) ? f - centre : centre - f;
        return diff < longint'(reg_window);
    endfunction

    // first match wins: data tones from the lowest, then guard a, guard b, separator
    function automatic logic [CLASS_W-1:0] tone_class(logic [FREQ_W-1:0] f);
        for (int i = 0; i < NUM_DATA_TONES; i++) begin
            if (tone_hit(f, longint'(reg_base) + longint'(i) * longint'(reg_spacing)))
                return CLASS_W'(i + 1);
        end
        if (tone_hit(f, reg_guard_a)) return CLASS_GUARD_A;
        if (tone_hit(f, reg_guard_b)) return CLASS_GUARD_B;
        if (tone_hit(f, reg_separator)) return CLASS_SEPARATOR;
        return CLASS_NONE;
    endfunction

    function automatic void clear_decoder();
        dec_phase      = STATUS_WAIT;
        dec_last_class = CLASS_NONE;
        dec_sym_count  = '0;
        dec_shift      = '0;
        dec_length     = '0;
        dec_received   = '0;
    endfunction

    // advance the decoder by one input beat and return the result beat it gives
    function automatic decoded_beat_t decode_step(logic restart, logic [FREQ_W-1:0] f);
        decoded_beat_t r;
        logic [CLASS_W-1:0] cls;
        int sh;
        r.byte_valid = 1'b0;
        r.data_byte  = '0;
        r.byte_index = '0;
        if (restart) begin
            clear_decoder();
        end else if (dec_phase != STATUS_DONE) begin
            cls = tone_class(f);
            // a repeated tone is dropped, guard a excepted
            if (cls != CLASS_NONE && (cls != dec_last_class || cls == CLASS_GUARD_A)) begin
                dec_last_class = cls;
                case (dec_phase)
                    STATUS_WAIT: begin
                        if (cls == CLASS_GUARD_A) dec_phase = STATUS_GUARD_A;
                    end
                    STATUS_GUARD_A: begin
                        if (cls == CLASS_GUARD_B) dec_phase = STATUS_HEADER;
                        else if (cls != CLASS_GUARD_A) dec_phase = STATUS_WAIT;
                    end
                    default: begin
                        // guards and separator only mark the last tone here
                        if (cls <= NUM_DATA_TONES) begin
                            sh = 8 - SYMBOL_BITS - int'(dec_sym_count) * SYMBOL_BITS;
                            dec_shift = 8'(dec_shift | ((int'(cls) - 1) << sh));
                            dec_sym_count = dec_sym_count + 1'b1;
                            if (dec_sym_count >= SYMS_PER_BYTE) begin
                                if (dec_phase == STATUS_HEADER) begin
                                    dec_length = dec_shift;
                                    dec_phase  = (dec_length == 0) ? STATUS_DONE : STATUS_BODY;
                                end else begin
                                    r.byte_valid = 1'b1;
                                    r.data_byte  = dec_shift;
                                    r.byte_index = dec_received;
                                    dec_received = dec_received + 1'b1;
                                    if (dec_received == dec_length) dec_phase = STATUS_DONE;
                                end
                                dec_sym_count = '0;
                                dec_shift     = '0;
                            end
                        end
                    end
                endcase
            end
        end
        r.status     = dec_phase;
        r.msg_length = dec_length;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, longint got, longint want);
        if (error_count < PRINT_LIMIT)
            $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
        error_count++;
    endtask

    // every result beat is compared with the oldest prediction
    always @(posedge aclk) begin
        decoded_beat_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (pending_beats.size() == 0) begin
                report_mismatch("result beat with nothing pending", m_tdata, 0);
            end else begin
                want = pending_beats.pop_front();
                if (m_tdata[STATUS_W-1:0] !== want.status)
                    report_mismatch("status", m_tdata[STATUS_W-1:0], want.status);
                if (m_tuser !== want.byte_valid)
                    report_mismatch("byte_valid", m_tuser, want.byte_valid);
                if (m_tdata[DBYTE_LSB +: 8] !== want.data_byte)
                    report_mismatch("data_byte", m_tdata[DBYTE_LSB +: 8], want.data_byte);
                if (m_tdata[DIDX_LSB +: 8] !== want.byte_index)
                    report_mismatch("byte_index", m_tdata[DIDX_LSB +: 8], want.byte_index);
                if (m_tdata[MLEN_LSB +: 8] !== want.msg_length)
                    report_mismatch("message_length", m_tdata[MLEN_LSB +: 8], want.msg_length);
                if (m_tdata[M_TDATA_W-1:M_USED_W] !== '0)
                    report_mismatch("tdata padding", m_tdata[M_TDATA_W-1:M_USED_W], 0);
            end
        end
    end

    // result side back-pressure: random bursts with tready low
    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_tready  <= 1'b0;
        end else if (sink_idle && $urandom_range(0, 7) == 0) begin
            sink_hold <= $urandom_range(0, 12);
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog: too long without any beat moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers, all entered and left at a rising edge
    // ------------------------------------------------------------------

    // one input beat; tvalid stays high on return so that a following beat can go
    // back to back, callers lower it through drain_decoder
    task automatic send_beat(logic restart, logic [FREQ_W-1:0] f);
        if (src_idle && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(f);
        s_tuser  <= restart;
        do @(posedge aclk); while (s_tready !== 1'b1);
        pending_beats.push_back(decode_step(restart, f));
        beats_sent++;
    endtask

    // wait until every owed result has come back and the pipeline has emptied
    task automatic drain_decoder();
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // leaves the write enable high so that writes go back to back
    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_addr <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        case (idx)
            REG_BASE_TONE:      reg_base      = value;
            REG_TONE_SPACING:   reg_spacing   = value;
            REG_GUARD_A_TONE:   reg_guard_a   = value;
            REG_GUARD_B_TONE:   reg_guard_b   = value;
            REG_SEPARATOR_TONE: reg_separator = value;
            REG_MATCH_WINDOW:   reg_window    = value[WIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_decoder(int base, int spacing, int guard_a, int guard_b,
                                   int separator, int window);
        drain_decoder();
        write_reg(REG_BASE_TONE, CFG_DATA_W'(base));
        write_reg(REG_TONE_SPACING, CFG_DATA_W'(spacing));
        write_reg(REG_GUARD_A_TONE, CFG_DATA_W'(guard_a));
        write_reg(REG_GUARD_B_TONE, CFG_DATA_W'(guard_b));
        write_reg(REG_SEPARATOR_TONE, CFG_DATA_W'(separator));
        write_reg(REG_MATCH_WINDOW, CFG_DATA_W'(window));
        cfg_wr_en <= 1'b0;
        repeat (2) @(posedge aclk);
    endtask

    // a frequency within the match window of a centre, clipped to the input range
    function automatic logic [FREQ_W-1:0] near_freq(longint centre);
        longint spread, f;
        spread = (reg_window > 1) ? longint'(reg_window) - 1 : 0;
        f = centre + longint'($urandom_range(0, 32'(2 * spread))) - spread;
        if (f < 0) f = 0;
        if (f > FREQ_MAX) f = FREQ_MAX;
        return FREQ_W'(f);
    endfunction

    function automatic logic [CLASS_W-1:0] data_class(int sym);
        return CLASS_W'(sym + 1);
    endfunction

    task automatic send_tone(logic [CLASS_W-1:0] cls);
        longint centre;
        case (cls)
            CLASS_GUARD_A:   centre = reg_guard_a;
            CLASS_GUARD_B:   centre = reg_guard_b;
            CLASS_SEPARATOR: centre = reg_separator;
            default:         centre = longint'(reg_base)
                                      + (longint'(cls) - 1) * longint'(reg_spacing);
        endcase
        send_beat(1'b0, near_freq(centre));
    endtask

    // a data symbol, with a separator (now and then a guard b) in front of a repeat
    task automatic send_symbol(int sym);
        if (dec_last_class == data_class(sym))
            send_tone(($urandom_range(0, 5) == 0) ? CLASS_GUARD_B : CLASS_SEPARATOR);
        send_tone(data_class(sym));
    endtask

    // one byte msb first, with the odd disturbance thrown in
    task automatic send_byte(int value);
        for (int k = 0; k < SYMS_PER_BYTE; k++) begin
            if (disturb && $urandom_range(0, 39) == 0) begin
                case ($urandom_range(0, 3))
                    0: send_beat(1'b0, FREQ_W'($urandom_range(0, FREQ_MAX)));
                    1: send_tone(CLASS_SEPARATOR);
                    2: send_tone(CLASS_GUARD_A);
                    default: send_beat(1'b1, FREQ_W'($urandom_range(0, FREQ_MAX)));
                endcase
            end
            send_symbol((value >> (8 - SYMBOL_BITS * (k + 1))) & (NUM_DATA_TONES - 1));
        end
    endtask

    // sync, header and body with random content
    task automatic send_frame(int len);
        if (dec_phase != STATUS_WAIT || $urandom_range(0, 3) == 0)
            send_beat(1'b1, FREQ_W'($urandom_range(0, FREQ_MAX)));
        repeat ($urandom_range(0, 2)) send_beat(1'b0, FREQ_W'($urandom_range(0, FREQ_MAX)));
        repeat ($urandom_range(1, 2)) send_tone(CLASS_GUARD_A);
        send_tone(CLASS_GUARD_B);
        send_byte(len);
        for (int i = 0; i < len; i++) send_byte($urandom_range(0, 255));
        // at most one guard a beat after the end, ignored once the transfer is complete
        repeat ($urandom_range(0, 1)) send_tone(CLASS_GUARD_A);
    endtask

    // mostly well-formed frames, some noise and stray restarts
    task automatic run_frames(int count);
        int stop_at;
        stop_at = beats_sent + count;
        while (beats_sent < stop_at) begin
            case ($urandom_range(0, 11))
                0: send_beat(1'b0, FREQ_W'($urandom_range(0, FREQ_MAX)));
                1: send_beat(1'b1, FREQ_W'($urandom_range(0, FREQ_MAX)));
                default: send_frame(($urandom_range(0, 14) == 0) ? $urandom_range(0, 40)
                                                                 : $urandom_range(0, 6));
            endcase
        end
    endtask

    task automatic program_random_tones();
        int window, spacing, base;
        window  = $urandom_range(1, 4000);
        spacing = $urandom_range(2 * window, 2 * window + 60000);
        base    = $urandom_range(0, FREQ_MAX - 3 * spacing);
        program_decoder(base, spacing, $urandom_range(0, FREQ_MAX),
                        $urandom_range(0, FREQ_MAX), $urandom_range(0, FREQ_MAX), window);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset values of the registers, no idling
    task automatic test_directed();
        send_beat(1'b1, FREQ_W'(FREQ_MAX));                // restart, frequency ignored
        send_beat(1'b0, FREQ_W'(reg_base + reg_window));   // exactly one window away, no match
        send_tone(CLASS_GUARD_A);
        send_tone(CLASS_GUARD_A);                          // repeated guard a still counts
        send_tone(data_class(1));                          // breaks the sync
        send_tone(CLASS_GUARD_A);
        send_tone(CLASS_GUARD_B);
        // zero length header, guards and separator between the repeats
        send_tone(data_class(0));
        send_tone(data_class(0));                          // repeat, dropped
        send_tone(CLASS_GUARD_B);
        send_tone(data_class(0));
        send_tone(CLASS_SEPARATOR);
        send_tone(data_class(0));
        send_tone(CLASS_GUARD_A);
        send_tone(data_class(0));                          // length zero: complete at once
        send_tone(CLASS_GUARD_A);                          // ignored until a restart
        send_beat(1'b1, '0);
        send_tone(CLASS_GUARD_A);
        send_tone(CLASS_GUARD_B);
        // length one, data tones hit at both edges of the window
        send_beat(1'b0, FREQ_W'(reg_base + reg_window - 1));
        send_tone(CLASS_SEPARATOR);
        send_beat(1'b0, FREQ_W'(reg_base - reg_window + 1));
        send_tone(CLASS_SEPARATOR);
        send_tone(data_class(0));
        send_tone(data_class(1));
        send_byte(8'hE4);                                  // every data tone once
        drain_decoder();
    endtask

    task automatic test_default_traffic();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        run_frames(120);
        drain_decoder();
    endtask

    // longest message: byte index runs up to 254, no stray restarts inside
    task automatic test_long_message();
        disturb = 1'b0;
        send_frame(255);
        drain_decoder();
        disturb = 1'b1;
    endtask

    task automatic test_register_extremes();
        // widest window over a tightly packed tone set
        program_decoder(0, 1, FREQ_MAX, 'h80000, 'hC0000, (1 << WIN_W) - 1);
        run_frames(30);
        // highest base and spacing, exact match only
        program_decoder(FREQ_MAX, FREQ_MAX, 0, 'h55555, 'hAAAAA, 1);
        run_frames(25);
        // zero window: nothing ever matches
        program_decoder(16000, 3200, 48000, 51200, 41600, 0);
        run_frames(15);
        drain_decoder();
    endtask

    task automatic test_random_settings();
        repeat (3) begin
            program_random_tones();
            run_frames(50);
        end
        drain_decoder();
    endtask

    // closing stretch without idling on either side
    task automatic test_full_rate();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        program_random_tones();
        run_frames(80);
        drain_decoder();
    endtask

    initial begin
        reg_base      = 16000;
        reg_spacing   = 3200;
        reg_guard_a   = 48000;
        reg_guard_b   = 51200;
        reg_separator = 41600;
        reg_window    = 800;
        clear_decoder();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_default_traffic();
        test_long_message();
        test_register_extremes();
        test_random_settings();
        test_full_rate();

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
